FILE: design/fsac_pkg.sv
`default_nettype none

package fsac_pkg;

    localparam int MAX_SAMPLES_DEF = 64;

    // Widths of the statistics, sized for the largest batch
    localparam int FUEL_W    = 16;
    localparam int SUM_W     = 22;
    localparam int MEAN_W    = 24;
    localparam int EFF_W     = 34;
    localparam int EFF_SUM_W = 40;
    localparam int SQ_W      = 48;
    localparam int SUMSQ_W   = 54;
    localparam int ROOT_W    = 27;

    // Shared divider
    localparam int DIV_W     = 54;
    localparam int DIVISOR_W = 16;
    localparam int ITER_W    = 6;

    // fuel * 1000 * 256
    localparam longint EFF_SCALE = 256000;

    localparam logic [11:0] HIGH_RATIO_RST    = 12'd384;
    localparam logic [11:0] SIGMA_MULT_RST    = 12'd768;
    localparam logic [9:0]  JUMP_FRACTION_RST = 10'd77;
    localparam logic [9:0]  EFF_TOL_RST       = 10'd128;

    localparam logic [2:0] REASON_NONE  = 3'd0;
    localparam logic [2:0] REASON_RATIO = 3'd1;
    localparam logic [2:0] REASON_SIGMA = 3'd2;
    localparam logic [2:0] REASON_JUMP  = 3'd3;
    localparam logic [2:0] REASON_EFF   = 3'd4;

    typedef enum logic [2:0] {
        CFG_HIGH_RATIO    = 3'd0,
        CFG_SIGMA_MULT    = 3'd1,
        CFG_JUMP_FRACTION = 3'd2,
        CFG_EFF_TOL       = 3'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_SUM_EFF,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_AVG,
        ST_AVG_WAIT,
        ST_VAR_RD,
        ST_VAR_D,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_VAR_DIV,
        ST_VAR_DIV_WAIT,
        ST_SQRT_WAIT,
        ST_THR_A,
        ST_THR_B,
        ST_CL_RD,
        ST_CL_CHK,
        ST_CL_EFF_WAIT,
        ST_CL_OUT
    } state_t;

    // Request to the shared divider; dividend is left-aligned to DIV_W
    typedef struct packed {
        logic                 start;
        logic [ITER_W-1:0]    iters;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

FILE: design/fsac_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module fsac_div
    import fsac_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    output logic                  busy,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ITER_W-1:0]    cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    always_comb
    begin
        logic [DIVISOR_W:0] shifted;
        logic               ge;
        shifted   = {rem_reg, num_reg[DIV_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = '0;
            den_next  = req.divisor;
            num_next  = req.dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVISOR_W'(shifted - {1'b0, den_reg}) : shifted[DIVISOR_W-1:0];
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/fsac_sqrt.sv
`default_nettype none

// Integer square root, one root bit (two radicand bits) per cycle.
module fsac_sqrt
    import fsac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   radicand,
    output logic                    busy,
    output logic                    done,
    output logic [ROOT_W-1:0]       root
);

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;

    always_comb
    begin
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        rem_sh    = {rem_reg, rad_reg[DIV_W-1 -: 2]};
        trial     = (REM_W+2)'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[DIV_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: design/fuel_sample_anomaly_classifier.sv
// Fuel sample anomaly classifier.
// s_* channel: one item per fuel/rpm sample; s_tlast marks the end of a batch.
// Samples load at one item per cycle into an internal store of MAX_SAMPLES
// entries; items past capacity are dropped (a dropped last still ends the batch).
// After the last item s_tready stays low while the batch is processed, then one
// verdict item per stored sample leaves on the m_* channel, m_tlast on the final.
// Processing for a batch of N samples, E of them with non-zero rpm, runs as:
//   a sum and efficiency pass (one divide per sample with non-zero rpm), the
//   mean and mean efficiency (no efficiency divide when E = 0), thresholds,
//   variance, divide and square root when N > 1, then each verdict
//   (efficiency divide only when needed).
// Processing time is set by the single shared divider (one quotient bit per cycle)
// and the bit-pair square root unit.
// The result sits in an output register; a stalled receiver holds it and the
// sequencer waits only when the next verdict is ready. A new batch may load
// while the final verdict still waits.
// Configuration: cfg_wen writes cfg_data to register cfg_index; write only while
// idle. Reset (rst_n low) restores register defaults and empties the batch.
`default_nettype none

module fuel_sample_anomaly_classifier
    import fsac_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] fuel_rate, [31:16] engine_speed
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [5:0] sample_index, [6] is_anomaly,
                                        // [9:7] reason_code, [33:10] batch_mean, zero pad
    output logic             m_tlast,   // last_result
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = $clog2(MAX_SAMPLES);

    // configuration
    logic [11:0] high_ratio_reg;
    logic [11:0] sigma_mult_reg;
    logic [9:0]  jump_fraction_reg;
    logic [9:0]  eff_tol_reg;

    // sample store
    logic [31:0] store [MAX_SAMPLES];
    logic [31:0] rd_data_reg;
    logic        store_wen;

    // control
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [IW-1:0] idx_reg, idx_next;

    // statistics
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [EFF_SUM_W-1:0] eff_sum_reg, eff_sum_next;
    logic [CW-1:0]        eff_cnt_reg, eff_cnt_next;
    logic [MEAN_W-1:0]    mean_reg, mean_next;
    logic [EFF_W-1:0]     avg_reg, avg_next;
    logic [MEAN_W-1:0]    d_reg, d_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [SUMSQ_W-1:0]   sumsq_reg, sumsq_next;
    logic [ROOT_W-1:0]    sigma_reg, sigma_next;
    logic [35:0]          thr_hi_reg, thr_hi_next;
    logic [38:0]          sig_prod_reg, sig_prod_next;
    logic [39:0]          thr_sig_reg, thr_sig_next;
    logic [33:0]          thr_jump_reg, thr_jump_next;
    logic [43:0]          thr_eff_reg, thr_eff_next;
    logic [FUEL_W-1:0]    prev_reg, prev_next;
    logic [2:0]           reason_reg, reason_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [IW-1:0]     out_index_reg, out_index_next;
    logic [2:0]        out_reason_reg, out_reason_next;
    logic [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic              out_last_reg, out_last_next;

    // shared divider and square root unit
    div_req_t          div_req;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;
    logic              sqrt_start;
    logic              sqrt_busy;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    fsac_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    fsac_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_ratio_reg    <= HIGH_RATIO_RST;
            sigma_mult_reg    <= SIGMA_MULT_RST;
            jump_fraction_reg <= JUMP_FRACTION_RST;
            eff_tol_reg       <= EFF_TOL_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_HIGH_RATIO:    high_ratio_reg    <= cfg_data;
                CFG_SIGMA_MULT:    sigma_mult_reg    <= cfg_data;
                CFG_JUMP_FRACTION: jump_fraction_reg <= cfg_data[9:0];
                CFG_EFF_TOL:       eff_tol_reg       <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    assign store_wen = (state_reg == ST_LOAD) && s_tvalid
                       && (count_reg < CW'(MAX_SAMPLES));

    always_ff @(posedge clk)
    begin
        if (store_wen)
        begin
            store[count_reg[IW-1:0]] <= s_tdata;
        end
        rd_data_reg <= store[idx_reg];
    end

    always_comb
    begin
        logic [FUEL_W-1:0]  fuel_rd;
        logic [FUEL_W-1:0]  rpm_rd;
        logic               last_idx;
        logic [EFF_W-1:0]   eff_num;
        logic [MEAN_W-1:0]  xs;
        logic [31:0]        x16;
        logic [FUEL_W-1:0]  jump;
        logic [EFF_W-1:0]   eff;
        logic [EFF_W-1:0]   eff_diff;
        logic [CW-1:0]      count_inc;

        fuel_rd   = rd_data_reg[15:0];
        rpm_rd    = rd_data_reg[31:16];
        last_idx  = (CW'(idx_reg) == n_reg - CW'(1));
        eff_num   = EFF_W'(fuel_rd) * EFF_W'(EFF_SCALE);
        xs        = {fuel_rd, 8'd0};
        x16       = {fuel_rd, 16'd0};
        jump      = (fuel_rd > prev_reg) ? fuel_rd - prev_reg : prev_reg - fuel_rd;
        eff       = div_q[EFF_W-1:0];
        eff_diff  = (eff > avg_reg) ? eff - avg_reg : avg_reg - eff;
        count_inc = count_reg + CW'(store_wen);

        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        eff_sum_next    = eff_sum_reg;
        eff_cnt_next    = eff_cnt_reg;
        mean_next       = mean_reg;
        avg_next        = avg_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        sumsq_next      = sumsq_reg;
        sigma_next      = sigma_reg;
        thr_hi_next     = thr_hi_reg;
        sig_prod_next   = sig_prod_reg;
        thr_sig_next    = thr_sig_reg;
        thr_jump_next   = thr_jump_reg;
        thr_eff_next    = thr_eff_reg;
        prev_next       = prev_reg;
        reason_next     = reason_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_index_next  = out_index_reg;
        out_reason_next = out_reason_reg;
        out_mean_next   = out_mean_reg;
        out_last_next   = out_last_reg;
        div_req         = '0;
        sqrt_start      = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    count_next = count_inc;
                    if (s_tlast)
                    begin
                        n_next       = count_inc;
                        idx_next     = '0;
                        sum_next     = '0;
                        eff_sum_next = '0;
                        eff_cnt_next = '0;
                        sumsq_next   = '0;
                        sigma_next   = '0;
                        state_next   = ST_SUM_RD;
                    end
                end
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                sum_next = sum_reg + SUM_W'(fuel_rd);
                if (rpm_rd != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(EFF_W);
                    div_req.dividend = {eff_num, {(DIV_W-EFF_W){1'b0}}};
                    div_req.divisor  = rpm_rd;
                    state_next       = ST_SUM_EFF;
                end
                else if (last_idx)
                begin
                    state_next = ST_MEAN;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_SUM_EFF:
            begin
                if (div_done)
                begin
                    eff_sum_next = eff_sum_reg + EFF_SUM_W'(eff);
                    eff_cnt_next = eff_cnt_reg + CW'(1);
                    if (last_idx)
                    begin
                        state_next = ST_MEAN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_SUM_RD;
                    end
                end
            end
            ST_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.iters    = ITER_W'(SUM_W + 8);
                div_req.dividend = {sum_reg, 8'd0, {(DIV_W-SUM_W-8){1'b0}}};
                div_req.divisor  = DIVISOR_W'(n_reg);
                state_next       = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = div_q[MEAN_W-1:0];
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                idx_next = '0;
                if (eff_cnt_reg != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(EFF_SUM_W);
                    div_req.dividend = {eff_sum_reg, {(DIV_W-EFF_SUM_W){1'b0}}};
                    div_req.divisor  = DIVISOR_W'(eff_cnt_reg);
                    state_next       = ST_AVG_WAIT;
                end
                else
                begin
                    avg_next   = '0;
                    state_next = (n_reg > CW'(1)) ? ST_VAR_RD : ST_THR_A;
                end
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_next   = div_q[EFF_W-1:0];
                    state_next = (n_reg > CW'(1)) ? ST_VAR_RD : ST_THR_A;
                end
            end
            ST_VAR_RD:
            begin
                state_next = ST_VAR_D;
            end
            ST_VAR_D:
            begin
                d_next     = (xs > mean_reg) ? xs - mean_reg : mean_reg - xs;
                state_next = ST_VAR_SQ;
            end
            ST_VAR_SQ:
            begin
                sq_next    = SQ_W'(d_reg) * SQ_W'(d_reg);
                state_next = ST_VAR_ACC;
            end
            ST_VAR_ACC:
            begin
                sumsq_next = sumsq_reg + SUMSQ_W'(sq_reg);
                if (last_idx)
                begin
                    state_next = ST_VAR_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_VAR_RD;
                end
            end
            ST_VAR_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.iters    = ITER_W'(SUMSQ_W);
                div_req.dividend = sumsq_reg;
                div_req.divisor  = DIVISOR_W'(n_reg - CW'(1));
                state_next       = ST_VAR_DIV_WAIT;
            end
            ST_VAR_DIV_WAIT:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    sigma_next = sqrt_root;
                    state_next = ST_THR_A;
                end
            end
            ST_THR_A:
            begin
                thr_hi_next   = 36'(mean_reg) * 36'(high_ratio_reg);
                sig_prod_next = 39'(sigma_reg) * 39'(sigma_mult_reg);
                thr_jump_next = 34'(mean_reg) * 34'(jump_fraction_reg);
                thr_eff_next  = 44'(avg_reg) * 44'(eff_tol_reg);
                state_next    = ST_THR_B;
            end
            ST_THR_B:
            begin
                thr_sig_next = 40'({mean_reg, 8'd0}) + 40'(sig_prod_reg);
                idx_next     = '0;
                state_next   = ST_CL_RD;
            end
            ST_CL_RD:
            begin
                state_next = ST_CL_CHK;
            end
            ST_CL_CHK:
            begin
                prev_next = fuel_rd;
                if (36'(x16) > thr_hi_reg)
                begin
                    reason_next = REASON_RATIO;
                    state_next  = ST_CL_OUT;
                end
                else if (40'(x16) > thr_sig_reg)
                begin
                    reason_next = REASON_SIGMA;
                    state_next  = ST_CL_OUT;
                end
                else if ((idx_reg != '0) && (34'({jump, 16'd0}) > thr_jump_reg))
                begin
                    reason_next = REASON_JUMP;
                    state_next  = ST_CL_OUT;
                end
                else if (rpm_rd != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.iters    = ITER_W'(EFF_W);
                    div_req.dividend = {eff_num, {(DIV_W-EFF_W){1'b0}}};
                    div_req.divisor  = rpm_rd;
                    state_next       = ST_CL_EFF_WAIT;
                end
                else
                begin
                    reason_next = REASON_NONE;
                    state_next  = ST_CL_OUT;
                end
            end
            ST_CL_EFF_WAIT:
            begin
                if (div_done)
                begin
                    reason_next = (44'({eff_diff, 8'd0}) > thr_eff_reg) ? REASON_EFF
                                                                        : REASON_NONE;
                    state_next  = ST_CL_OUT;
                end
            end
            ST_CL_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = idx_reg;
                    out_reason_next = reason_reg;
                    out_mean_next   = mean_reg;
                    out_last_next   = last_idx;
                    if (last_idx)
                    begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_CL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        eff_sum_reg    <= eff_sum_next;
        eff_cnt_reg    <= eff_cnt_next;
        mean_reg       <= mean_next;
        avg_reg        <= avg_next;
        d_reg          <= d_next;
        sq_reg         <= sq_next;
        sumsq_reg      <= sumsq_next;
        sigma_reg      <= sigma_next;
        thr_hi_reg     <= thr_hi_next;
        sig_prod_reg   <= sig_prod_next;
        thr_sig_reg    <= thr_sig_next;
        thr_jump_reg   <= thr_jump_next;
        thr_eff_reg    <= thr_eff_next;
        prev_reg       <= prev_next;
        reason_reg     <= reason_next;
        out_index_reg  <= out_index_next;
        out_reason_reg <= out_reason_next;
        out_mean_reg   <= out_mean_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_mean_reg, out_reason_reg,
                       (out_reason_reg != REASON_NONE), 6'(out_index_reg)};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count past capacity");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:7] <= REASON_EFF))
        else $error("reason code out of range");

    a_anomaly_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] == (m_tdata[9:7] != REASON_NONE)))
        else $error("anomaly flag disagrees with reason");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root restarted while busy");
`endif

endmodule

`default_nettype wire
